[sv/swm_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// swm_pkg: shared definitions for the sliding window median
// Sample and result widths, configuration width, defaults and the per-cycle
// step control broadcast along the sorted cell chain.
// ============================================================================
package swm_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int MEDIAN_W       = 33;
    localparam int CFG_W          = 7;
    localparam int WINDOW_MAX_DEF = 64;
    localparam int WINDOW_RST     = 3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [MEDIAN_W-1:0] t_median;
    typedef logic        [CFG_W-1:0]    t_cfg;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic load;    // a sample transfer happens this cycle
        logic del_en;  // the window is full: the oldest sample leaves
        logic clear;   // window size written: empty the chain
    } t_step;

endpackage

[sv/swm_sample_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// swm_sample_if: sample input channel
// Valid/ready channel that carries one signed sample per transfer.
// ============================================================================
interface swm_sample_if;
    logic            valid;
    logic            ready;
    swm_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[sv/swm_median_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// swm_median_if: median result channel
// Valid/ready channel that carries twice the window median per transfer.
// ============================================================================
interface swm_median_if;
    logic             valid;
    logic             ready;
    swm_pkg::t_median median_twice;

    modport source (output valid, output median_twice, input ready);
    modport sink   (input valid, input median_twice, output ready);
endinterface

[sv/swm_cfg_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// swm_cfg_if: window size write channel
// Valid/ready channel that writes the window size register.
// ============================================================================
interface swm_cfg_if;
    logic          valid;
    logic          ready;
    swm_pkg::t_cfg window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

[sv/swm_cell.sv]
`timescale 1ns / 1ps
// ============================================================================
// swm_cell: one slot of the sorted window chain
// Holds one sample with its age. Each step it drops the oldest sample by
// shifting down from its right neighbor, then makes room for the new sample
// by shifting up from its left neighbor, keeping the chain in ascending order.
// ============================================================================
module swm_cell #(
    parameter int AW = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  swm_pkg::t_step   i_step,
    input  swm_pkg::t_sample i_sample,
    input  swm_pkg::t_sample i_oldest,
    input  logic [AW-1:0]    i_last_age,
    // right neighbor state
    input  swm_pkg::t_sample i_nxt_value,
    input  logic [AW-1:0]    i_nxt_age,
    input  logic             i_nxt_valid,
    input  logic             i_nxt_gt,
    // left neighbor after removal
    input  swm_pkg::t_sample i_prv_u_value,
    input  logic [AW-1:0]    i_prv_u_age,
    input  logic             i_prv_u_valid,
    input  logic             i_prv_gu,
    // own state, for the left neighbor and the median select
    output swm_pkg::t_sample o_value,
    output logic [AW-1:0]    o_age,
    output logic             o_valid,
    output logic             o_gt,
    // own slot after removal, for the right neighbor
    output swm_pkg::t_sample o_u_value,
    output logic [AW-1:0]    o_u_age,
    output logic             o_u_valid,
    output logic             o_gu
);

    swm_pkg::t_sample r_value;
    logic [AW-1:0]    r_age;
    logic             r_valid;
    swm_pkg::t_sample n_value;
    logic [AW-1:0]    n_age;
    logic             n_valid;
    logic             above_del;

    // Equal values sit oldest first, so the age breaks ties against the
    // sample that leaves.
    always_comb begin
        o_gt      = !r_valid || (r_value > i_sample);
        above_del = i_step.del_en && (!r_valid || (r_value > i_oldest) ||
                    ((r_value == i_oldest) && (r_age <= i_last_age)));
        o_u_value = above_del ? i_nxt_value : r_value;
        o_u_age   = above_del ? i_nxt_age   : r_age;
        o_u_valid = above_del ? i_nxt_valid : r_valid;
        o_gu      = above_del ? i_nxt_gt    : o_gt;

        if (i_prv_gu) begin
            n_value = i_prv_u_value;
            n_age   = i_prv_u_age + AW'(1);
            n_valid = i_prv_u_valid;
        end else if (o_gu) begin
            n_value = i_sample;
            n_age   = '0;
            n_valid = 1'b1;
        end else begin
            n_value = o_u_value;
            n_age   = o_u_age + AW'(1);
            n_valid = o_u_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step.clear) begin
            r_valid <= 1'b0;
        end else if (i_step.load) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.load) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_value = r_value;
    assign o_age   = r_age;
    assign o_valid = r_valid;

endmodule

[sv/sliding_window_median.sv]
`timescale 1ns / 1ps
// ============================================================================
// sliding_window_median: running median filter over a sample stream
// Keeps the most recent samples in arrival order and in a sorted cell chain
// and returns twice the median of the window.
// ============================================================================
// Usage:
//   i_sample carries one signed 32-bit sample per transfer. o_median returns
//   median_twice, twice the window median as a signed 33-bit value (the sum
//   of the two middle samples for an even window). i_cfg writes the window
//   size (0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX); a write
//   also empties the window. Write it only while no result is outstanding.
//   The first window_size-1 samples after reset or a write give no result;
//   every later sample gives one.
// Timing:
//   On each sample transfer the whole sorted chain removes the oldest
//   sample and inserts the new one together. The median is read from
//   the updated chain into the output register, which drives o_median,
//   once that register is free or being taken. One sample per cycle
//   is sustained while o_median is taken. If o_median stalls, i_sample
//   ready drops as soon as a median is pending and stays low until the
//   output register frees up.
// Reset:
//   Synchronous, active low. Window size returns to 3, the window is emptied,
//   and no result is pending. No clearing pass is needed.
// ============================================================================
module sliding_window_median #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    swm_cfg_if.sink       i_cfg,
    swm_sample_if.sink    i_sample,
    swm_median_if.source  o_median
);

    localparam int AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WW      = $clog2(WINDOW_MAX + 1);
    localparam int CW      = (WW > swm_pkg::CFG_W) ? WW : swm_pkg::CFG_W;
    localparam int RST_WIN = (swm_pkg::WINDOW_RST > WINDOW_MAX) ?
                             WINDOW_MAX : swm_pkg::WINDOW_RST;

    logic [WW-1:0]    r_window;
    logic [WW-1:0]    r_fill;
    logic [AW-1:0]    r_ptr;
    logic [AW-1:0]    n_ptr;
    logic [AW-1:0]    rd_addr;
    swm_pkg::t_sample r_oldest;
    swm_pkg::t_sample r_ring [WINDOW_MAX];
    logic             r_pend;
    logic             r_out_valid;
    swm_pkg::t_median r_out_data;

    logic             accept;
    logic             cfg_we;
    logic             full;
    logic             due;
    logic             move;
    logic [CW-1:0]    cfg_ext;
    logic [WW-1:0]    n_window;
    logic [AW:0]      ptr_plus;
    logic [AW-1:0]    last_age;
    logic [AW-1:0]    idx_hi;
    logic [AW-1:0]    idx_lo;
    logic [WW-1:0]    mid;
    swm_pkg::t_sample med_hi;
    swm_pkg::t_sample med_lo;
    swm_pkg::t_median med_sum;
    swm_pkg::t_step   step;

    swm_pkg::t_sample cell_value [WINDOW_MAX];
    logic [AW-1:0]    cell_age   [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] cell_valid;
    logic [WINDOW_MAX-1:0] cell_gt;
    swm_pkg::t_sample u_value    [WINDOW_MAX];
    logic [AW-1:0]    u_age      [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] u_valid;
    logic [WINDOW_MAX-1:0] gu;

    // ------------------------------------------------------------------
    // Handshakes and window bookkeeping
    // ------------------------------------------------------------------
    assign cfg_we         = i_cfg.valid;
    assign i_cfg.ready    = 1'b1;
    assign move           = r_pend && (!r_out_valid || o_median.ready);
    assign i_sample.ready = !r_pend || !r_out_valid || o_median.ready;
    assign accept         = i_sample.valid && i_sample.ready;

    assign full     = (r_fill == r_window);
    assign due      = full || ((r_fill + WW'(1)) == r_window);
    assign last_age = AW'(r_window - WW'(1));

    always_comb begin
        cfg_ext = CW'(i_cfg.window_size);
        if (cfg_ext == '0) begin
            n_window = WW'(1);
        end else if (cfg_ext > CW'(WINDOW_MAX)) begin
            n_window = WW'(WINDOW_MAX);
        end else begin
            n_window = WW'(cfg_ext);
        end
    end

    always_comb begin
        ptr_plus = {1'b0, r_ptr} + (AW + 1)'(1);
        if (cfg_we) begin
            n_ptr = '0;
        end else if (accept) begin
            n_ptr = (32'(ptr_plus) >= 32'(r_window)) ? '0 : ptr_plus[AW-1:0];
        end else begin
            n_ptr = r_ptr;
        end
        rd_addr = n_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WW'(RST_WIN);
            r_fill   <= '0;
            r_ptr    <= '0;
        end else begin
            r_ptr <= n_ptr;
            if (cfg_we) begin
                r_window <= n_window;
                r_fill   <= '0;
            end else if (accept && !full) begin
                r_fill <= r_fill + WW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Arrival ring: the read port prefetches the slot that leaves next.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_ptr] <= i_sample.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (rd_addr == r_ptr)) begin
            r_oldest <= i_sample.sample;
        end else begin
            r_oldest <= r_ring[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Sorted cell chain
    // ------------------------------------------------------------------
    assign step.load   = accept;
    assign step.del_en = full;
    assign step.clear  = cfg_we;

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        swm_pkg::t_sample nxt_value;
        logic [AW-1:0]    nxt_age;
        logic             nxt_valid;
        logic             nxt_gt;
        swm_pkg::t_sample prv_u_value;
        logic [AW-1:0]    prv_u_age;
        logic             prv_u_valid;
        logic             prv_gu;

        if (i == WINDOW_MAX - 1) begin : g_last
            assign nxt_value = '0;
            assign nxt_age   = '0;
            assign nxt_valid = 1'b0;
            assign nxt_gt    = 1'b1;
        end else begin : g_mid
            assign nxt_value = cell_value[i+1];
            assign nxt_age   = cell_age[i+1];
            assign nxt_valid = cell_valid[i+1];
            assign nxt_gt    = cell_gt[i+1];
        end

        if (i == 0) begin : g_first
            assign prv_u_value = '0;
            assign prv_u_age   = '0;
            assign prv_u_valid = 1'b0;
            assign prv_gu      = 1'b0;
        end else begin : g_rest
            assign prv_u_value = u_value[i-1];
            assign prv_u_age   = u_age[i-1];
            assign prv_u_valid = u_valid[i-1];
            assign prv_gu      = gu[i-1];
        end

        swm_cell #(
            .AW (AW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_step        (step),
            .i_sample      (i_sample.sample),
            .i_oldest      (r_oldest),
            .i_last_age    (last_age),
            .i_nxt_value   (nxt_value),
            .i_nxt_age     (nxt_age),
            .i_nxt_valid   (nxt_valid),
            .i_nxt_gt      (nxt_gt),
            .i_prv_u_value (prv_u_value),
            .i_prv_u_age   (prv_u_age),
            .i_prv_u_valid (prv_u_valid),
            .i_prv_gu      (prv_gu),
            .o_value       (cell_value[i]),
            .o_age         (cell_age[i]),
            .o_valid       (cell_valid[i]),
            .o_gt          (cell_gt[i]),
            .o_u_value     (u_value[i]),
            .o_u_age       (u_age[i]),
            .o_u_valid     (u_valid[i]),
            .o_gu          (gu[i])
        );
    end

    // ------------------------------------------------------------------
    // Median select from the chain registers, captured by the output register
    // ------------------------------------------------------------------
    always_comb begin
        mid     = r_window >> 1;
        idx_hi  = mid[AW-1:0];
        idx_lo  = idx_hi - AW'(1);
        med_hi  = cell_value[idx_hi];
        med_lo  = r_window[0] ? med_hi : cell_value[idx_lo];
        med_sum = {med_hi[swm_pkg::SAMPLE_W-1], med_hi} +
                  {med_lo[swm_pkg::SAMPLE_W-1], med_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pend <= due;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_median.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_data <= med_sum;
        end
    end

    assign o_median.valid        = r_out_valid;
    assign o_median.median_twice = r_out_data;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_window)
        else $error("fill count exceeds window size");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ptr) < 32'(r_window))
        else $error("ring pointer outside the window");

    a_chain_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(cell_valid) == int'(r_fill))
        else $error("occupied cells disagree with fill count");

    a_result_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> o_median.valid)
        else $error("pending median not presented");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_out_valid && !o_median.ready) |-> !i_sample.ready)
        else $error("sample taken while median is blocked");
`endif

endmodule

[tb/tb_sliding_window_median.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_sliding_window_median: self-checking bench for the running median filter
// Streams signed samples into the block, keeps its own sorted window and ring
// to predict twice the median of each full window, and compares every result
// transfer against the oldest prediction. Window sizes are rewritten between
// phases, including zero and values beyond the largest window.
// ============================================================================
module tb_sliding_window_median;

    localparam int CLK_HALF   = 4;
    localparam int WIN_MAX    = swm_pkg::WINDOW_MAX_DEF;
    localparam int CYCLE_CAP  = 400_000;
    localparam int RANDOM_END = 1700;
    localparam int DRAIN_WAIT = 4;
    localparam swm_pkg::t_sample SMP_MAX = 32'sh7FFF_FFFF;
    localparam swm_pkg::t_sample SMP_MIN = 32'sh8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swm_cfg_if    cfg_bus ();
    swm_sample_if sample_bus ();
    swm_median_if median_bus ();

    sliding_window_median dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_sample (sample_bus),
        .o_median (median_bus)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Predicted window state.
    swm_pkg::t_sample arrival_ring [WIN_MAX];
    swm_pkg::t_sample sorted_win   [WIN_MAX];
    int               win_len;
    int               fill_cnt;
    int               ring_ptr;
    swm_pkg::t_median median_expect [$];

    bit idle_on = 1'b1;
    int fail_count;
    int samples_sent;
    int medians_seen;
    int cfg_writes;
    int cycle_count;

    function automatic void window_reset_model();
        win_len  = swm_pkg::WINDOW_RST;
        fill_cnt = 0;
        ring_ptr = 0;
    endfunction

    function automatic void window_size_model(input swm_pkg::t_cfg value);
        if (value == 0)
            win_len = 1;
        else if (int'(value) > WIN_MAX)
            win_len = WIN_MAX;
        else
            win_len = int'(value);
        fill_cnt = 0;
        ring_ptr = 0;
    endfunction

    function automatic void predict_median(input swm_pkg::t_sample s);
        int               w;
        int               p;
        int               i;
        swm_pkg::t_median m;
        w = win_len;
        p = (ring_ptr >= w) ? 0 : ring_ptr;
        if (fill_cnt < w) begin
            i = fill_cnt;
            fill_cnt++;
        end else begin
            // Drop one copy of the oldest sample, then open the top slot.
            i = 0;
            while (i < w && sorted_win[i] != arrival_ring[p])
                i++;
            while (i + 1 < w) begin
                sorted_win[i] = sorted_win[i + 1];
                i++;
            end
            i = w - 1;
        end
        while (i > 0 && sorted_win[i - 1] > s) begin
            sorted_win[i] = sorted_win[i - 1];
            i--;
        end
        sorted_win[i] = s;
        arrival_ring[p] = s;
        p++;
        ring_ptr = (p >= w) ? 0 : p;
        if (fill_cnt == w) begin
            if (w % 2 == 1)
                m = swm_pkg::t_median'(sorted_win[w / 2]) * 2;
            else
                m = swm_pkg::t_median'(sorted_win[w / 2 - 1]) +
                    swm_pkg::t_median'(sorted_win[w / 2]);
            median_expect.insert(median_expect.size(), m);
        end
    endfunction

    function automatic swm_pkg::t_sample pick_sample(input int mode);
        case (mode)
            0: return swm_pkg::t_sample'($urandom);
            1: return swm_pkg::t_sample'($urandom_range(0, 6)) - 3;
            2: begin
                case ($urandom_range(0, 3))
                    0: return SMP_MIN;
                    1: return SMP_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return SMP_MAX - swm_pkg::t_sample'($urandom_range(0, 7));
        endcase
    endfunction

    // Called right after a rising edge; leaves valid high after the transfer.
    task automatic send_sample(input swm_pkg::t_sample s);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            sample_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= s;
        @(posedge i_clk);
        while (!sample_bus.ready)
            @(posedge i_clk);
        predict_median(s);
        samples_sent++;
    endtask

    // Wait for the block to go idle, then write the window size.
    task automatic write_window(input swm_pkg::t_cfg value);
        sample_bus.valid <= 1'b0;
        while (median_expect.size() != 0)
            @(posedge i_clk);
        // A filling sample leaves no result behind, so allow for its latency.
        repeat (DRAIN_WAIT) @(posedge i_clk);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.window_size <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        window_size_model(value);
        cfg_writes++;
    endtask

    task automatic test_default_window();
        swm_pkg::t_sample vals [8] = '{SMP_MAX, SMP_MIN, 0, SMP_MAX,
                                       SMP_MAX, SMP_MIN, SMP_MIN, SMP_MIN};
        foreach (vals[k])
            send_sample(vals[k]);
    endtask

    task automatic test_unit_window();
        write_window(swm_pkg::t_cfg'(0));
        send_sample(5);
        send_sample(-7);
        write_window(swm_pkg::t_cfg'(1));
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
    endtask

    task automatic test_even_window();
        swm_pkg::t_sample vals [7] = '{SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN,
                                       SMP_MAX, -1, 0};
        write_window(swm_pkg::t_cfg'(2));
        foreach (vals[k])
            send_sample(vals[k]);
    endtask

    task automatic test_duplicate_values();
        swm_pkg::t_sample vals [6] = '{3, 3, 3, -2, 3, 3};
        write_window(swm_pkg::t_cfg'(4));
        foreach (vals[k])
            send_sample(vals[k]);
    endtask

    task automatic test_random_windows();
        int            phase;
        int            count;
        int            bias;
        swm_pkg::t_cfg value;
        phase = 0;
        while (samples_sent < RANDOM_END) begin
            // Open with the saturating and largest sizes, then mostly small windows.
            case (phase)
                0: value = swm_pkg::t_cfg'(127);
                1: value = swm_pkg::t_cfg'(WIN_MAX);
                2: value = swm_pkg::t_cfg'(WIN_MAX + 1);
                default: begin
                    if ($urandom_range(0, 7) == 0)
                        value = swm_pkg::t_cfg'($urandom_range(0, 127));
                    else
                        value = swm_pkg::t_cfg'($urandom_range(0, 10));
                end
            endcase
            write_window(value);
            idle_on = ($urandom_range(0, 3) != 0);
            bias = $urandom_range(0, 3);
            // Some phases stop while the window is still filling.
            if ($urandom_range(0, 5) == 0)
                count = $urandom_range(1, win_len);
            else
                count = win_len + $urandom_range(0, 40);
            repeat (count)
                send_sample(pick_sample($urandom_range(0, 1) ? bias : $urandom_range(0, 3)));
            phase++;
        end
    endtask

    task automatic test_streaming();
        idle_on = 1'b0;
        write_window(swm_pkg::t_cfg'(5));
        repeat (50)
            send_sample(pick_sample($urandom_range(0, 3)));
        sample_bus.valid <= 1'b0;
    endtask

    initial begin : out_ready_gen
        int stall_left;
        stall_left = 0;
        median_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                median_bus.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                median_bus.ready <= 1'b0;
            end else begin
                median_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_median
        swm_pkg::t_median want;
        if (i_rst_n && median_bus.valid && median_bus.ready) begin
            medians_seen++;
            if (median_expect.size() == 0) begin
                $error("median_twice: no result expected, got %0d", median_bus.median_twice);
                fail_count++;
            end else begin
                want = median_expect.pop_front();
                if (median_bus.median_twice !== want) begin
                    $error("median_twice: expected %0d, got %0d", want,
                           median_bus.median_twice);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("tb_sliding_window_median failed");
            $finish;
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.window_size <= '0;
        sample_bus.valid    <= 1'b0;
        sample_bus.sample   <= '0;
        window_reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_window();
        test_unit_window();
        test_even_window();
        test_duplicate_values();
        test_random_windows();
        test_streaming();

        while (median_expect.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d samples across %0d window size writes (sizes 0 to 127).",
                 samples_sent, cfg_writes);
        $display("Checked %0d median results with random gaps and output stalls.",
                 medians_seen);
        if (fail_count == 0)
            $display("tb_sliding_window_median passed");
        else
            $display("tb_sliding_window_median failed");
        $finish;
    end

endmodule
